@@ rtl/nsp_pkg.sv @@
// Shared types, constants and the pixel format conversion for the
// nearest-neighbor scale and pixel convert unit. No dependencies.
`default_nettype none

package nsp_pkg;

    // Field widths
    localparam int FRAC_BITS  = 16;
    localparam int ACC_W      = 29;
    localparam int DIM_W      = 13;
    localparam int COORD_W    = 12;
    localparam int PITCH_W    = 15;
    localparam int INDEX_W    = 24;
    localparam int ADDR_W     = 26;
    localparam int PIXEL_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;
    localparam int SRC_POS_W  = ACC_W - FRAC_BITS;

    localparam logic [DIM_W-1:0] MAX_DIM = DIM_W'(4096);

    // Command queue geometry
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Divider step counter
    localparam int DIV_CNT_W = $clog2(ACC_W);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_FORMAT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_BGRA      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_PITCH     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_STRIDE    = 3'd7;

    // Source formats
    localparam logic [1:0] FMT_RGB565   = 2'd0;
    localparam logic [1:0] FMT_RGB1555  = 2'd1;
    localparam logic [1:0] FMT_XRGB8888 = 2'd2;

    // Item kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef struct packed {
        logic [1:0]         source_format;
        logic               out_bgra;
        logic [DIM_W-1:0]   src_width;
        logic [DIM_W-1:0]   src_height;
        logic [PITCH_W-1:0] src_pitch;
        logic [DIM_W-1:0]   dst_width;
        logic [DIM_W-1:0]   dst_height;
        logic [DIM_W-1:0]   dst_row_stride;
    } cfg_t;

    typedef struct packed {
        logic               kind;
        logic [PIXEL_W-1:0] pixel_in;
    } in_item_t;

    typedef struct packed {
        logic               write_valid;
        logic [INDEX_W-1:0] dest_index;
        logic [PIXEL_W-1:0] pixel_out;
        logic               read_valid;
        logic [ADDR_W-1:0]  read_address;
        logic               frame_done;
    } out_item_t;

    // Work for the back end, classified by the front end
    typedef enum logic [1:0] {
        OP_START      = 2'd0,
        OP_START_NULL = 2'd1,
        OP_PIXEL      = 2'd2
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [PIXEL_W-1:0] pixel;
    } cmd_t;

    // Limit a size register to the largest supported dimension
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        return (v > MAX_DIM) ? MAX_DIM : v;
    endfunction

    // Widen a 5-bit channel to 8 bits by replicating its high bits
    function automatic logic [7:0] widen5(input logic [4:0] c);
        return {c, c[4:2]};
    endfunction

    // Widen a 6-bit channel to 8 bits by replicating its high bits
    function automatic logic [7:0] widen6(input logic [5:0] c);
        return {c, c[5:4]};
    endfunction

    // Convert a source word to RGBA8888 or BGRA8888 with opaque alpha
    function automatic logic [PIXEL_W-1:0] convert_pixel(
        input logic [1:0]         fmt,
        input logic               bgra,
        input logic [PIXEL_W-1:0] p
    );
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        priority if (fmt == FMT_RGB565) begin
            r = widen5(p[15:11]);
            g = widen6(p[10:5]);
            b = widen5(p[4:0]);
        end else if (fmt == FMT_RGB1555) begin
            r = widen5(p[14:10]);
            g = widen5(p[9:5]);
            b = widen5(p[4:0]);
        end else begin
            // XRGB8888 and the unused code
            b = p[7:0];
            g = p[15:8];
            r = p[23:16];
        end
        if (bgra)
            return {ALPHA_OPAQUE, r, g, b};
        return {ALPHA_OPAQUE, b, g, r};
    endfunction

endpackage

`default_nettype wire

@@ rtl/nsp_front.sv @@
// Front end: accepts input beats, classifies them and converts pixel words.
// Depends on nsp_pkg; feeds nsp_queue.
`default_nettype none

module nsp_front (
    input  wire nsp_pkg::cfg_t     cfg,
    input  wire                    item_valid,
    output logic                   item_stall,
    input  wire nsp_pkg::in_item_t item_data,
    input  wire                    queue_full,
    output logic                   push,
    output nsp_pkg::cmd_t          push_data
);
    import nsp_pkg::*;

    logic size_zero;

    // Hold the beat while the queue has no room
    assign item_stall = queue_full;
    assign push       = item_valid && !queue_full;

    // A start with any zero size becomes a null start that runs no division
    assign size_zero = (cfg.src_width == '0) || (cfg.src_height == '0) ||
                       (cfg.dst_width == '0) || (cfg.dst_height == '0);

    // Classify the beat and convert the pixel word
    always_comb
    begin
        push_data.pixel = '0;
        if (item_data.kind == KIND_PIXEL)
        begin
            push_data.op    = OP_PIXEL;
            push_data.pixel = convert_pixel(cfg.source_format, cfg.out_bgra,
                                            item_data.pixel_in);
        end
        else if (size_zero)
        begin
            push_data.op = OP_START_NULL;
        end
        else
        begin
            push_data.op = OP_START;
        end
    end

endmodule

`default_nettype wire

@@ rtl/nsp_queue.sv @@
// Short command queue between the front end and the back end.
// Depends on nsp_pkg for the command type and depth.
`default_nettype none

module nsp_queue (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push,
    input  wire nsp_pkg::cmd_t  push_data,
    output logic                full,
    input  wire                 pop,
    output nsp_pkg::cmd_t       pop_data,
    output logic                empty
);
    import nsp_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed command
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

@@ rtl/nsp_divider.sv @@
// Iterative restoring divider for the fixed-point scale steps, one quotient
// bit per cycle. Depends on nsp_pkg for widths.
`default_nettype none

module nsp_divider (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              start,
    input  wire [nsp_pkg::ACC_W-1:0]         dividend,
    input  wire [nsp_pkg::DIM_W-1:0]         divisor,
    output logic                             done,
    output logic [nsp_pkg::ACC_W-1:0]        quotient
);
    import nsp_pkg::*;

    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [DIV_CNT_W-1:0] count_reg;
    logic [DIV_CNT_W-1:0] count_next;
    logic [ACC_W-1:0]     quot_reg;
    logic [ACC_W-1:0]     quot_next;
    logic [DIM_W-1:0]     rem_reg;
    logic [DIM_W-1:0]     rem_next;
    logic [DIM_W-1:0]     divisor_reg;
    logic [DIM_W-1:0]     divisor_next;
    logic [DIM_W:0]       trial;
    logic [DIM_W:0]       diff;

    assign done     = done_reg;
    assign quotient = quot_reg;

    // Shift in the next dividend bit and try the subtraction
    assign trial = {rem_reg, quot_reg[ACC_W-1]};
    assign diff  = trial - {1'b0, divisor_reg};

    always_comb
    begin
        busy_next    = busy_reg;
        count_next   = count_reg;
        quot_next    = quot_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        done_next    = 1'b0;
        if (start)
        begin
            busy_next    = 1'b1;
            count_next   = DIV_CNT_W'(ACC_W - 1);
            quot_next    = dividend;
            rem_next     = '0;
            divisor_next = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor_reg})
            begin
                rem_next  = diff[DIM_W-1:0];
                quot_next = {quot_reg[ACC_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[DIM_W-1:0];
                quot_next = {quot_reg[ACC_W-2:0], 1'b0};
            end
            count_next = count_reg - 1'b1;
            if (count_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg    <= quot_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

endmodule

`default_nettype wire

@@ rtl/nsp_back.sv @@
// Back end: owns the stepping state, runs the step divisions, forms the
// destination index and next source address and holds the result beat.
// Depends on nsp_pkg and nsp_divider.
`default_nettype none

module nsp_back (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire nsp_pkg::cfg_t      cfg,
    input  wire                     queue_empty,
    input  wire nsp_pkg::cmd_t      queue_data,
    output logic                    queue_pop,
    output logic                    result_valid,
    input  wire                     result_stall,
    output nsp_pkg::out_item_t      result_data
);
    import nsp_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_DIV_H = 5'b00010,
        ST_DIV_V = 5'b00100,
        ST_ADDR  = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    out_item_t          res_reg;
    out_item_t          res_next;
    logic [ACC_W-1:0]   horiz_step_reg;
    logic [ACC_W-1:0]   horiz_step_next;
    logic [ACC_W-1:0]   vert_step_reg;
    logic [ACC_W-1:0]   vert_step_next;
    logic [ACC_W-1:0]   horiz_acc_reg;
    logic [ACC_W-1:0]   horiz_acc_next;
    logic [ACC_W-1:0]   vert_acc_reg;
    logic [ACC_W-1:0]   vert_acc_next;
    logic [COORD_W-1:0] dest_col_reg;
    logic [COORD_W-1:0] dest_col_next;
    logic [COORD_W-1:0] dest_row_reg;
    logic [COORD_W-1:0] dest_row_next;
    logic               frame_active_reg;
    logic               frame_active_next;

    logic [DIM_W-1:0]   sw;
    logic [DIM_W-1:0]   sh;
    logic [DIM_W-1:0]   dw;
    logic [DIM_W-1:0]   dh;
    logic [DIM_W-1:0]   stride;
    logic [24:0]        index_prod;
    logic [INDEX_W-1:0] index_sum;
    logic [SRC_POS_W-1:0] src_x;
    logic [SRC_POS_W-1:0] src_y;
    logic [27:0]        row_offset;
    logic [PITCH_W-1:0] col_offset;
    logic [ADDR_W-1:0]  src_addr;
    logic               col_last;
    logic               row_last;

    logic               div_start;
    logic [ACC_W-1:0]   div_dividend;
    logic [DIM_W-1:0]   div_divisor;
    logic               div_done;
    logic [ACC_W-1:0]   div_quotient;

    nsp_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Effective sizes
    assign sw     = clamp_dim(cfg.src_width);
    assign sh     = clamp_dim(cfg.src_height);
    assign dw     = clamp_dim(cfg.dst_width);
    assign dh     = clamp_dim(cfg.dst_height);
    assign stride = (cfg.dst_row_stride != '0) ? cfg.dst_row_stride : dw;

    // Destination index from the current position
    assign index_prod = 25'(dest_row_reg) * 25'(stride);
    assign index_sum  = index_prod[INDEX_W-1:0] + INDEX_W'(dest_col_reg);

    // Source byte address from the stepped position
    assign src_x      = horiz_acc_reg[ACC_W-1:FRAC_BITS];
    assign src_y      = vert_acc_reg[ACC_W-1:FRAC_BITS];
    assign row_offset = 28'(src_y) * 28'(cfg.src_pitch);
    assign col_offset = (cfg.source_format == FMT_RGB565 ||
                         cfg.source_format == FMT_RGB1555)
                        ? {1'b0, src_x, 1'b0} : {src_x, 2'b00};
    assign src_addr   = row_offset[ADDR_W-1:0] + ADDR_W'(col_offset);

    assign col_last = ({1'b0, dest_col_reg} + 1'b1) >= dw;
    assign row_last = ({1'b0, dest_row_reg} + 1'b1) >= dh;

    assign queue_pop    = (state_reg == ST_IDLE) && !queue_empty;
    assign result_valid = (state_reg == ST_OUT);
    assign result_data  = res_reg;

    always_comb
    begin
        state_next        = state_reg;
        res_next          = res_reg;
        horiz_step_next   = horiz_step_reg;
        vert_step_next    = vert_step_reg;
        horiz_acc_next    = horiz_acc_reg;
        vert_acc_next     = vert_acc_reg;
        dest_col_next     = dest_col_reg;
        dest_row_next     = dest_row_reg;
        frame_active_next = frame_active_reg;
        div_start         = 1'b0;
        div_dividend      = {sw, FRAC_BITS'(0)};
        div_divisor       = dw;

        unique case (state_reg)
            ST_IDLE:
            begin
                // Take the next command
                if (!queue_empty)
                begin
                    res_next = '0;
                    unique case (queue_data.op)
                        OP_START_NULL:
                        begin
                            horiz_acc_next    = '0;
                            vert_acc_next     = '0;
                            dest_col_next     = '0;
                            dest_row_next     = '0;
                            frame_active_next = 1'b0;
                            state_next        = ST_OUT;
                        end
                        OP_START:
                        begin
                            horiz_acc_next      = '0;
                            vert_acc_next       = '0;
                            dest_col_next       = '0;
                            dest_row_next       = '0;
                            frame_active_next   = 1'b1;
                            res_next.read_valid = 1'b1;
                            div_start           = 1'b1;
                            state_next          = ST_DIV_H;
                        end
                        OP_PIXEL:
                        begin
                            if (!frame_active_reg || dw == '0 || dh == '0)
                            begin
                                state_next = ST_OUT;
                            end
                            else
                            begin
                                res_next.write_valid = 1'b1;
                                res_next.dest_index  = index_sum;
                                res_next.pixel_out   = queue_data.pixel;
                                if (col_last)
                                begin
                                    dest_col_next  = '0;
                                    horiz_acc_next = '0;
                                    if (row_last)
                                    begin
                                        dest_row_next       = '0;
                                        vert_acc_next       = '0;
                                        frame_active_next   = 1'b0;
                                        res_next.frame_done = 1'b1;
                                        state_next          = ST_OUT;
                                    end
                                    else
                                    begin
                                        dest_row_next       = dest_row_reg + 1'b1;
                                        vert_acc_next       = vert_acc_reg + vert_step_reg;
                                        res_next.read_valid = 1'b1;
                                        state_next          = ST_ADDR;
                                    end
                                end
                                else
                                begin
                                    dest_col_next       = dest_col_reg + 1'b1;
                                    horiz_acc_next      = horiz_acc_reg + horiz_step_reg;
                                    res_next.read_valid = 1'b1;
                                    state_next          = ST_ADDR;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_DIV_H:
            begin
                // Latch the horizontal step, then divide the height
                if (div_done)
                begin
                    horiz_step_next = div_quotient;
                    div_start       = 1'b1;
                    div_dividend    = {sh, FRAC_BITS'(0)};
                    div_divisor     = dh;
                    state_next      = ST_DIV_V;
                end
            end
            ST_DIV_V:
            begin
                if (div_done)
                begin
                    vert_step_next = div_quotient;
                    state_next     = ST_ADDR;
                end
            end
            ST_ADDR:
            begin
                res_next.read_address = src_addr;
                state_next            = ST_OUT;
            end
            ST_OUT:
            begin
                // Hold the beat until the sink takes it
                if (!result_stall)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            horiz_step_reg   <= '0;
            vert_step_reg    <= '0;
            horiz_acc_reg    <= '0;
            vert_acc_reg     <= '0;
            dest_col_reg     <= '0;
            dest_row_reg     <= '0;
            frame_active_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            horiz_step_reg   <= horiz_step_next;
            vert_step_reg    <= vert_step_next;
            horiz_acc_reg    <= horiz_acc_next;
            vert_acc_reg     <= vert_acc_next;
            dest_col_reg     <= dest_col_next;
            dest_row_reg     <= dest_row_next;
            frame_active_reg <= frame_active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule

`default_nettype wire

@@ rtl/nearest_scale_pixel_convert_unit.sv @@
// Top level of the nearest-neighbor scale and pixel convert unit: register
// bank, front end, command queue and back end. Depends on nsp_pkg and all nsp_ modules.
//
// Every input beat gives exactly one result beat, in order. In the back end
// a pixel beat goes through position update and destination index, then
// source address, then result presentation, which holds while the sink
// stalls. The last pixel of a frame and a pixel that arrives with no frame
// running skip the source address, as they request none. For a start beat
// the back end runs two 29-bit divisions, width then height, on one shared
// divider that retires one quotient bit per cycle, latching each step, then
// forms the source address. A start with any zero size runs no division.
// A two-entry queue lets the front end keep taking beats while the back end
// works or its result waits. The source word arriving with a pixel beat is
// converted with the format registers as they stand at that moment;
// registers may only be written while no beat is in flight.
`default_nettype none

module nearest_scale_pixel_convert_unit (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 cfg_write,
    input  wire [nsp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire [nsp_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  wire                                 item_valid,
    output logic                                item_stall,
    input  wire nsp_pkg::in_item_t              item_data,
    output logic                                result_valid,
    input  wire                                 result_stall,
    output nsp_pkg::out_item_t                  result_data
);
    import nsp_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic queue_full;
    logic queue_empty;
    logic push;
    cmd_t push_data;
    logic pop;
    cmd_t pop_data;

    // Register bank write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_SOURCE_FORMAT: cfg_next.source_format  = cfg_data[1:0];
                CFG_OUT_BGRA:      cfg_next.out_bgra       = cfg_data[0];
                CFG_SRC_WIDTH:     cfg_next.src_width      = cfg_data[DIM_W-1:0];
                CFG_SRC_HEIGHT:    cfg_next.src_height     = cfg_data[DIM_W-1:0];
                CFG_SRC_PITCH:     cfg_next.src_pitch      = cfg_data[PITCH_W-1:0];
                CFG_DST_WIDTH:     cfg_next.dst_width      = cfg_data[DIM_W-1:0];
                CFG_DST_HEIGHT:    cfg_next.dst_height     = cfg_data[DIM_W-1:0];
                CFG_DST_STRIDE:    cfg_next.dst_row_stride = cfg_data[DIM_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.source_format  <= FMT_RGB565;
            cfg_reg.out_bgra       <= 1'b0;
            cfg_reg.src_width      <= DIM_W'(1);
            cfg_reg.src_height     <= DIM_W'(1);
            cfg_reg.src_pitch      <= PITCH_W'(4);
            cfg_reg.dst_width      <= DIM_W'(1);
            cfg_reg.dst_height     <= DIM_W'(1);
            cfg_reg.dst_row_stride <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    nsp_front u_front (
        .cfg        (cfg_reg),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item_data  (item_data),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data)
    );

    nsp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (queue_empty)
    );

    nsp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .queue_empty  (queue_empty),
        .queue_data   (pop_data),
        .queue_pop    (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

endmodule

`default_nettype wire
